// ===== sv/tss_pkg.sv =====
// shared types and constants for the triangle scanline span block
package tss_pkg;

  // coordinate width, fixed by the item format
  localparam int CoordBits = 16;
  // one quotient bit per divider stage
  localparam int DivStages = CoordBits;
  // register stages: subtract, multiply, divider, crossing add, merge/output
  localparam int NumStages = 2 + DivStages + 2;
  localparam int NumEdges  = 3;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [CoordBits-1:0]        mag_t;
  typedef logic [2*CoordBits-1:0]      num_t;

  typedef struct packed {
    coord_t vertex_a_x;
    coord_t vertex_a_y;
    coord_t vertex_b_x;
    coord_t vertex_b_y;
    coord_t vertex_c_x;
    coord_t vertex_c_y;
    coord_t row_y;
  } in_item_t;

  typedef struct packed {
    logic   span_valid;
    coord_t span_left;
    coord_t span_right;
  } out_item_t;

  // edge operands entering the divider
  typedef struct packed {
    logic   hit;
    logic   neg;
    coord_t x1;
    num_t   num;
    mag_t   den;
  } div_in_t;

  // edge result leaving the divider
  typedef struct packed {
    logic   hit;
    logic   neg;
    coord_t x1;
    mag_t   quot;
  } div_out_t;

endpackage

// ===== sv/tss_edge_prep.sv =====
// edge setup: hit test, magnitudes and the numerator product, two stages
module tss_edge_prep (
  input  logic             clk,
  input  logic             en_sub,
  input  logic             en_mul,
  input  tss_pkg::coord_t  x1,
  input  tss_pkg::coord_t  y1,
  input  tss_pkg::coord_t  x2,
  input  tss_pkg::coord_t  y2,
  input  tss_pkg::coord_t  row,
  output tss_pkg::div_in_t div_in
);
  import tss_pkg::*;

  function automatic mag_t mag_of(input logic signed [CoordBits:0] v);
    logic [CoordBits:0] n;
    n = v[CoordBits] ? (~v + 1'b1) : v;
    return n[CoordBits-1:0];
  endfunction

  logic signed [CoordBits:0] dy_s, dx_s, dd_s;
  logic   hit_nxt, hit_r, neg_nxt, neg_r;
  coord_t x1_r;
  mag_t   a_nxt, a_r, b_nxt, b_r, den_nxt, den_r;
  num_t   num_nxt;
  div_in_t div_r;

  // stage 1: differences in one extra bit, then magnitudes
  always_comb begin
    dy_s    = {row[CoordBits-1], row} - {y1[CoordBits-1], y1};
    dx_s    = {x2[CoordBits-1], x2} - {x1[CoordBits-1], x1};
    dd_s    = {y2[CoordBits-1], y2} - {y1[CoordBits-1], y1};
    hit_nxt = (y1 != y2) && (((y1 <= row) && (row <= y2)) || ((y2 <= row) && (row <= y1)));
    neg_nxt = dx_s[CoordBits];
    a_nxt   = mag_of(dy_s);
    b_nxt   = mag_of(dx_s);
    den_nxt = mag_of(dd_s);
  end

  always_ff @(posedge clk) begin
    if (en_sub) begin
      hit_r <= hit_nxt;
      neg_r <= neg_nxt;
      x1_r  <= x1;
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      den_r <= den_nxt;
    end
  end

  // stage 2: numerator |y-y1|*|dx|, fits in twice the coordinate width
  assign num_nxt = num_t'(a_r) * num_t'(b_r);

  always_ff @(posedge clk) begin
    if (en_mul) begin
      div_r.hit <= hit_r;
      div_r.neg <= neg_r;
      div_r.x1  <= x1_r;
      div_r.num <= num_nxt;
      div_r.den <= den_r;
    end
  end

  assign div_in = div_r;

endmodule

// ===== sv/tss_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module tss_div (
  input  logic                               clk,
  input  logic [tss_pkg::DivStages-1:0]      en,
  input  tss_pkg::div_in_t                   div_in,
  output tss_pkg::div_out_t                  div_out
);
  import tss_pkg::*;

  typedef struct packed {
    logic   hit;
    logic   neg;
    coord_t x1;
    num_t   rem;
    mag_t   den;
    mag_t   quot;
  } div_stg_t;

  div_stg_t stg_r   [DivStages];
  div_stg_t stg_nxt [DivStages];

  for (genvar k = 0; k < DivStages; k++) begin : g_stg
    localparam int Sh = DivStages - 1 - k;
    div_stg_t src;
    num_t     dsh;

    if (k == 0) begin : g_first
      always_comb begin
        src.hit  = div_in.hit;
        src.neg  = div_in.neg;
        src.x1   = div_in.x1;
        src.rem  = div_in.num;
        src.den  = div_in.den;
        src.quot = '0;
      end
    end else begin : g_next
      assign src = stg_r[k-1];
    end

    // quotient stays below 2^CoordBits since |y-y1| <= |y2-y1|
    always_comb begin
      dsh          = num_t'(src.den) << Sh;
      stg_nxt[k]   = src;
      if (src.rem >= dsh) begin
        stg_nxt[k].rem      = src.rem - dsh;
        stg_nxt[k].quot[Sh] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign div_out.hit  = stg_r[DivStages-1].hit;
  assign div_out.neg  = stg_r[DivStages-1].neg;
  assign div_out.x1   = stg_r[DivStages-1].x1;
  assign div_out.quot = stg_r[DivStages-1].quot;

endmodule

// ===== sv/tss_span_merge.sv =====
// crossing add per edge, then min and max over the hit edges
module tss_span_merge (
  input  logic               clk,
  input  logic               en_add,
  input  logic               en_out,
  input  tss_pkg::div_out_t  edge_res [tss_pkg::NumEdges],
  output tss_pkg::out_item_t span
);
  import tss_pkg::*;

  logic signed [CoordBits:0] sum [NumEdges];
  coord_t    cross_nxt [NumEdges];
  coord_t    cross_r   [NumEdges];
  logic [NumEdges-1:0] hit_r;
  out_item_t span_nxt, span_r;

  // x1 +/- quotient, result lies between the edge's x values
  always_comb begin
    for (int e = 0; e < NumEdges; e++) begin
      if (edge_res[e].neg) begin
        sum[e] = {edge_res[e].x1[CoordBits-1], edge_res[e].x1} - {1'b0, edge_res[e].quot};
      end else begin
        sum[e] = {edge_res[e].x1[CoordBits-1], edge_res[e].x1} + {1'b0, edge_res[e].quot};
      end
      cross_nxt[e] = coord_t'(sum[e][CoordBits-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en_add) begin
      for (int e = 0; e < NumEdges; e++) begin
        cross_r[e] <= cross_nxt[e];
        hit_r[e]   <= edge_res[e].hit;
      end
    end
  end

  always_comb begin
    span_nxt = '0;
    for (int e = 0; e < NumEdges; e++) begin
      if (hit_r[e]) begin
        if (!span_nxt.span_valid) begin
          span_nxt.span_valid = 1'b1;
          span_nxt.span_left  = cross_r[e];
          span_nxt.span_right = cross_r[e];
        end else begin
          if (cross_r[e] < span_nxt.span_left) begin
            span_nxt.span_left = cross_r[e];
          end
          if (cross_r[e] > span_nxt.span_right) begin
            span_nxt.span_right = cross_r[e];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      span_r <= span_nxt;
    end
  end

  assign span = span_r;

endmodule

// ===== sv/triangle_scanline_span.sv =====
// top level of the triangle scanline span block
// Takes one item per clock when not stalled: three triangle vertices and a
// scanline y, all signed 16-bit fixed point. For each edge a-b, b-c, c-a
// that is not horizontal and whose y range (ends included) holds the
// scanline, the crossing x = x1 + (y-y1)*(x2-x1)/(y2-y1) is formed with the
// quotient truncated toward zero; the result gives the smallest and largest
// crossing and span_valid, with both x fields zero when no edge is hit. The
// pipe has one stage for the differences, one for the multiply, 16 stages
// of restoring division at one quotient bit per stage for each edge, one
// for the crossing add and one for the min/max output register. Throughput
// is one item per cycle when the output is not stalled. Every stage has its
// own valid bit and loads when it is empty or its successor moves, so
// bubbles close up and input keeps flowing at a stalled output until full.
module triangle_scanline_span (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tss_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output tss_pkg::out_item_t out_item
);
  import tss_pkg::*;

  // stage map of the valid and enable vectors
  localparam int StgSub = 0;
  localparam int StgMul = 1;
  localparam int StgDiv = 2;
  localparam int StgAdd = StgDiv + DivStages;
  localparam int StgOut = StgAdd + 1;

  logic [NumStages-1:0] vld_r, vld_nxt;
  logic [NumStages-1:0] rdy;

  coord_t    vx [NumEdges];
  coord_t    vy [NumEdges];
  div_in_t   div_in  [NumEdges];
  div_out_t  div_out [NumEdges];
  out_item_t span;

  // stage i loads when it is empty or its contents move on
  always_comb begin
    rdy[NumStages-1] = !vld_r[NumStages-1] || !out_stall;
    for (int i = NumStages - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  // valid bits follow the data through the pipe
  always_comb begin
    for (int i = 0; i < NumStages; i++) begin
      if (rdy[i]) begin
        vld_nxt[i] = (i == 0) ? in_valid : vld_r[(i == 0) ? 0 : i - 1];
      end else begin
        vld_nxt[i] = vld_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !rdy[StgSub];
  assign out_valid = vld_r[StgOut];
  assign out_item  = span;

  // vertex table so that edge e runs from vertex e to vertex e+1
  assign vx[0] = in_item.vertex_a_x;
  assign vy[0] = in_item.vertex_a_y;
  assign vx[1] = in_item.vertex_b_x;
  assign vy[1] = in_item.vertex_b_y;
  assign vx[2] = in_item.vertex_c_x;
  assign vy[2] = in_item.vertex_c_y;

  for (genvar e = 0; e < NumEdges; e++) begin : g_edge
    localparam int En = (e + 1) % NumEdges;

    tss_edge_prep u_prep (
      .clk    (clk),
      .en_sub (rdy[StgSub]),
      .en_mul (rdy[StgMul]),
      .x1     (vx[e]),
      .y1     (vy[e]),
      .x2     (vx[En]),
      .y2     (vy[En]),
      .row    (in_item.row_y),
      .div_in (div_in[e])
    );

    tss_div u_div (
      .clk     (clk),
      .en      (rdy[StgAdd-1:StgDiv]),
      .div_in  (div_in[e]),
      .div_out (div_out[e])
    );
  end

  tss_span_merge u_merge (
    .clk      (clk),
    .en_add   (rdy[StgAdd]),
    .en_out   (rdy[StgOut]),
    .edge_res (div_out),
    .span     (span)
  );

  // an empty result never carries stale x values
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.span_valid) |->
      (out_item.span_left == '0 && out_item.span_right == '0))
    else $error("invalid span with nonzero x");

  // min and max are ordered
  a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.span_valid) |->
      (out_item.span_left <= out_item.span_right))
    else $error("span left above right");

  // an empty first stage never pushes back on the input
  a_first_free: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[StgSub] |-> !in_stall)
    else $error("input stalled with empty first stage");

  // an accepted item occupies the first stage on the next edge
  a_take_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[StgSub])
    else $error("accepted item lost at entry");

endmodule
